// ===== hw/rtl/byte_stack_push_pop_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte stack.
// Each macro expects clk and rst in scope and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BYTE_STACK_PUSH_POP_ASSERT_SVH
`define BYTE_STACK_PUSH_POP_ASSERT_SVH

// The condition holds at every clock edge.
`define BSP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg
// Types and codes shared by the byte stack, its channels and its testbench.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int NUM_BANKS = 8;
  localparam int BANK_W    = 3;
  localparam int FILL_W    = 9;

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_PEEK = 2'd1,
    MODE_POP  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  byte_count;
    logic [63:0] write_bytes;
  } req_t;

  typedef struct packed {
    logic [63:0]       read_bytes;
    logic [1:0]        status;
    logic [FILL_W-1:0] fill_level;
  } rsp_t;

endpackage

// ===== hw/rtl/bsp_req_if.sv =====
// ----------------------------------------------------------------------------
// bsp_req_if
// Request channel of the byte stack: valid, ready and one request.
// ----------------------------------------------------------------------------
interface bsp_req_if import bsp_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bsp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bsp_rsp_if
// Response channel of the byte stack: valid, ready and one result.
// ----------------------------------------------------------------------------
interface bsp_rsp_if import bsp_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/byte_stack_push_pop.sv =====
// Timing: an accepted request is read from the byte banks into their read
// registers; the aligned result is then loaded into the output register once
// that register is free or its result is taken. No new request is taken before then.
// Reset: the top pointer is cleared and the output register empties.
// The byte store is not cleared; entries are defined once pushed.
// ----------------------------------------------------------------------------
// byte_stack_push_pop
// Byte-granular stack held in eight byte-wide memory banks, so that all
// bytes of one push, peek or pop are written or read in a single access.
// ----------------------------------------------------------------------------
`include "byte_stack_push_pop_assert.svh"

module byte_stack_push_pop import bsp_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int MAX_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  bsp_req_if.sink     req,
  bsp_rsp_if.source   rsp
);

  localparam int PTR_W = $clog2(CAPACITY + 1);
  localparam int ROWS  = (CAPACITY + NUM_BANKS - 1) / NUM_BANKS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [3:0] MAX_CNT = 4'(MAX_BYTES);

  state_t state_q, state_next;

  logic [PTR_W-1:0]  top_q, top_next;
  status_t           st_q;
  logic              rd_ok_q;
  logic [3:0]        cnt_q;
  logic [BANK_W-1:0] lo_q;
  logic [FILL_W-1:0] fill_q;

  logic              accept;
  logic              load;
  logic              is_push, is_read;
  logic [3:0]        cnt;
  logic [PTR_W:0]    push_sum;
  logic [PTR_W-1:0]  base;
  logic              overflow, underflow;
  status_t           st_c;

  logic [7:0]        bank_rd [NUM_BANKS];
  logic [63:0]       rdata;

  assign accept = req.valid && req.ready;

  always_comb begin
    cnt       = (req.data.byte_count > MAX_CNT) ? MAX_CNT : req.data.byte_count;
    is_push   = (req.data.mode == MODE_PUSH);
    is_read   = (req.data.mode == MODE_PEEK) || (req.data.mode == MODE_POP);
    push_sum  = {1'b0, top_q} + (PTR_W + 1)'(cnt);
    overflow  = is_push && (push_sum > (PTR_W + 1)'(CAPACITY));
    underflow = is_read && (PTR_W'(cnt) > top_q);
    base      = top_q - PTR_W'(cnt);
    st_c      = overflow ? ST_OVERFLOW : (underflow ? ST_UNDERFLOW : ST_OK);
    top_next  = top_q;
    if (is_push && !overflow) begin
      top_next = push_sum[PTR_W-1:0];
    end else if ((req.data.mode == MODE_POP) && !underflow) begin
      top_next = base;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [BANK_W-1:0] off_w, off_r;
    logic [PTR_W-2:0]  row_w, row_r;
    logic              we;

    always_comb begin
      off_w = BANK_W'(b) - top_q[BANK_W-1:0];
      off_r = BANK_W'(b) - base[BANK_W-1:0];
      row_w = (PTR_W - 1)'(top_q[PTR_W-1:BANK_W])
              + (PTR_W - 1)'(BANK_W'(b) < top_q[BANK_W-1:0]);
      row_r = (PTR_W - 1)'(base[PTR_W-1:BANK_W])
              + (PTR_W - 1)'(BANK_W'(b) < base[BANK_W-1:0]);
      we    = accept && is_push && !overflow && ({1'b0, off_w} < cnt);
    end

    bsp_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk     (clk),
      .wr_en   (we),
      .wr_addr (row_w[ROW_W-1:0]),
      .wr_data (req.data.write_bytes[{off_w, 3'b000} +: 8]),
      .rd_en   (accept),
      .rd_addr (row_r[ROW_W-1:0]),
      .rd_data (bank_rd[b])
    );
  end

  always_comb begin
    rdata = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      if (rd_ok_q && (4'(i) < cnt_q)) begin
        rdata[8*i +: 8] = bank_rd[lo_q + BANK_W'(i)];
      end
    end
  end

  always_comb begin
    state_next = state_q;
    req.ready  = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (!rsp.valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q   <= S_IDLE;
      top_q     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state_q <= state_next;
      if (accept) begin
        top_q <= top_next;
      end
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_q    <= st_c;
      rd_ok_q <= is_read && !underflow;
      cnt_q   <= cnt;
      lo_q    <= base[BANK_W-1:0];
      fill_q  <= FILL_W'(top_next);
    end
    if (load) begin
      rsp.data.read_bytes <= rdata;
      rsp.data.status     <= st_q;
      rsp.data.fill_level <= fill_q;
    end
  end

  `BSP_ASSERT_ALWAYS(a_top_in_range, top_q <= PTR_W'(CAPACITY),
    "top pointer exceeds capacity")
  `BSP_ASSERT_IMP(a_refused_keeps_top, (state_q == S_READ) && (st_q != ST_OK),
    top_q == $past(top_q), "refused transaction changed the top pointer")
  `BSP_ASSERT_NEXT(a_accept_to_read, accept, state_q == S_READ,
    "accepted transaction did not start a memory read")

endmodule

// ===== hw/rtl/bsp_ram.sv =====
// ----------------------------------------------------------------------------
// bsp_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/byte_stack_push_pop_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stack_push_pop_tb
// Drives push, peek and pop requests into the byte stack and checks every
// reply against a shadow copy of the stack kept in the testbench. A short
// directed pass covers empty-stack refusals, zero and oversized counts, the
// unused mode and byte ordering. Random traffic then fills the stack to
// capacity and drains it to empty again, under three back-pressure profiles.
// ----------------------------------------------------------------------------
module byte_stack_push_pop_tb;
  import bsp_pkg::*;

  localparam int CAPACITY  = 256;
  localparam int MAX_BYTES = 8;

  logic clk = 1'b0;
  logic rst;

  bsp_req_if req_ch ();
  bsp_rsp_if rsp_ch ();

  byte_stack_push_pop #(
    .CAPACITY(CAPACITY),
    .MAX_BYTES(MAX_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  logic [7:0]  stack_mem [CAPACITY];
  int unsigned stack_top = 0;
  rsp_t        replies_due [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  always #1 clk = ~clk;

  function automatic rsp_t predict_stack(req_t r);
    rsp_t        res;
    int unsigned n;
    res = '0;
    n = (r.byte_count > MAX_BYTES) ? MAX_BYTES : r.byte_count;
    case (mode_t'(r.mode))
      MODE_PUSH: begin
        if (stack_top + n > CAPACITY) begin
          res.status = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < n; i++) stack_mem[stack_top + i] = r.write_bytes[8*i +: 8];
          stack_top += n;
        end
      end
      MODE_PEEK, MODE_POP: begin
        if (n > stack_top) begin
          res.status = ST_UNDERFLOW;
        end else begin
          for (int i = 0; i < n; i++) res.read_bytes[8*i +: 8] = stack_mem[stack_top - n + i];
          if (mode_t'(r.mode) == MODE_POP) stack_top -= n;
        end
      end
      default: begin
      end
    endcase
    res.fill_level = FILL_W'(stack_top);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    replies_due.push_back(predict_stack(r));
    @(negedge clk);
  endtask

  task automatic issue(mode_t m, logic [3:0] cnt, logic [63:0] data);
    req_t r;
    r.mode        = m;
    r.byte_count  = cnt;
    r.write_bytes = data;
    issue_request(r);
  endtask

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %h", $time, rsp_ch.data);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.data.read_bytes !== want.read_bytes) begin
          $display("%0t: read_bytes mismatch, expected %h, actual %h",
                   $time, want.read_bytes, rsp_ch.data.read_bytes);
          mismatch_count++;
        end
        if (rsp_ch.data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp_ch.data.status);
          mismatch_count++;
        end
        if (rsp_ch.data.fill_level !== want.fill_level) begin
          $display("%0t: fill_level mismatch, expected %0d, actual %0d",
                   $time, want.fill_level, rsp_ch.data.fill_level);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_stack();
    issue(MODE_POP, 4'd1, 64'h0);
    issue(MODE_PEEK, 4'd8, 64'h0);
    issue(MODE_PEEK, 4'd0, 64'h0);
    issue(MODE_POP, 4'd0, 64'h0);
    issue(MODE_PUSH, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(MODE_NONE, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(MODE_POP, 4'd15, 64'h0);
  endtask

  task automatic test_push_peek_pop();
    issue(MODE_PUSH, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(MODE_PUSH, 4'd8, 64'h0123_4567_89AB_CDEF);
    issue(MODE_PUSH, 4'd15, 64'hFEDC_BA98_7654_3210);
    issue(MODE_PUSH, 4'd1, 64'hFFFF_FFFF_FFFF_FF5A);
    issue(MODE_PUSH, 4'd3, 64'h1122_3344_55A5_C33C);
    issue(MODE_PEEK, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(MODE_PEEK, 4'd12, 64'h0);
    issue(MODE_POP, 4'd4, 64'h0);
    issue(MODE_NONE, 4'd3, 64'h0);
    issue(MODE_PUSH, 4'd8, 64'h0);
    issue(MODE_PEEK, 4'd8, 64'h0);
    issue(MODE_POP, 4'd15, 64'h0);
    issue(MODE_POP, 4'd8, 64'h0);
    issue(MODE_POP, 4'd8, 64'h0);
    issue(MODE_PEEK, 4'd9, 64'h0);
    issue(MODE_POP, 4'd8, 64'h0);
    issue(MODE_POP, 4'd1, 64'h0);
  endtask

  // The stack is driven toward full until it holds exactly its capacity,
  // then toward empty until it holds nothing, so both refusals are reached.
  task automatic test_random_traffic(int send_idle, int recv_idle, int n_items);
    req_t r;
    int   sent;
    int   pick;
    bit   filling;
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    sent    = 0;
    filling = 1'b1;
    while (sent < n_items) begin
      if (stack_top == CAPACITY) filling = 1'b0;
      else if (stack_top == 0) filling = 1'b1;
      pick          = $urandom_range(99);
      r.write_bytes = {$urandom, $urandom};
      r.byte_count  = ($urandom_range(99) < 80) ? 4'($urandom_range(8))
                                                : 4'($urandom_range(15, 9));
      if (pick < 5) r.mode = MODE_NONE;
      else if (pick < (filling ? 60 : 25)) r.mode = MODE_PUSH;
      else if (pick < (filling ? 75 : 40)) r.mode = MODE_PEEK;
      else r.mode = MODE_POP;
      issue_request(r);
      if (r.mode != MODE_NONE) sent++;
    end
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_push_peek_pop();
    test_random_traffic(29, 84, 552);
    test_random_traffic(84, 29, 552);
    test_random_traffic(0, 0, 552);
    req_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_req_if.sv
hw/rtl/bsp_rsp_if.sv
hw/rtl/bsp_ram.sv
hw/rtl/byte_stack_push_pop.sv
sim/byte_stack_push_pop_tb.sv
